// ===== design/sobel_pkg.sv =====
package sobel_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4095;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 12;
	localparam int CFG_DATA_W     = 12;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int PIX_W = 24;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [7:0] chan_t;

	// One channel of a packed pixel: red in bits 0-7, green 8-15, blue 16-23.
	function automatic chan_t pix_chan(input pixel_t p, input logic [1:0] ch);
		chan_t v;
		case (ch)
			2'd0:    v = p[7:0];
			2'd1:    v = p[15:8];
			default: v = p[23:16];
		endcase
		return v;
	endfunction

endpackage

// ===== design/sobel_ram.sv =====
module sobel_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sobel_edge_magnitude_rgb.sv =====
// Sobel 3x3 edge magnitude on an RGB raster stream.
// Input channel (in_valid / in_stall): operation selects a new pixel or a drain
// item; pixels arrive in raster order, one frame of frame_width x frame_height.
// Output channel (out_valid / out_stall): the rounded gradient magnitude of each
// color, capped at 255, and frame_last on the frame's final result.
// A result for pixel (r,c) appears with the input of pixel (r+1,c+1), so the
// stream lags by one row plus one pixel; after the last pixel, one drain item
// per pending result flushes the rest of the frame.
// The block works on one item at a time. Its pace is set by the eight-step
// magnitude search (one 9x9 square per step and channel) and by the single read
// port of each line store, which a drain item uses three times in a row unless
// its result is at the right edge of a row other than the last.
// A finished result sits in an output register; the next item is taken while it
// waits, and only a second result stalls behind it until the receiver takes it.
// Reset clears the window, counters and output valid flag, sets the frame size
// to 640 x 480 and leaves the line stores uncleared; unwritten entries feed only
// masked taps. Configuration is to be written only while idle; nothing enforces it.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic                             cfg_index,
	input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       edge_red,
	output logic [7:0]                       edge_green,
	output logic [7:0]                       edge_blue,
	output logic                             frame_last
);

	import sobel_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int XB = (RW > AW) ? RW : AW;
	localparam int XW = ((XB > FRAME_HEIGHT_W) ? XB : FRAME_HEIGHT_W) + 2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PRD  = 4'd1;
	localparam logic [3:0] ST_PWB  = 4'd2;
	localparam logic [3:0] ST_DCHK = 4'd3;
	localparam logic [3:0] ST_DRD  = 4'd4;
	localparam logic [3:0] ST_E1   = 4'd5;
	localparam logic [3:0] ST_E2   = 4'd6;
	localparam logic [3:0] ST_SRCH = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;

	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [XW-1:0]             eff_w;
	logic [XW-1:0]             eff_h;

	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	pixel_t window_q [9];
	pixel_t taps_q [9];
	pixel_t pix_q;
	logic   end_pend_q;

	logic [AW-1:0] eo_col_q;
	logic [RW-1:0] eo_row_q;
	logic          last_q;

	logic [1:0] di_q;
	logic       rd_ok_q;

	logic signed [11:0] gx_q [3];
	logic signed [11:0] gy_q [3];
	logic [23:0]        m4_q [3];
	logic [7:0]         n_q [3];
	logic [2:0]         bit_q;

	logic       out_valid_q;
	logic [7:0] edge_red_q;
	logic [7:0] edge_green_q;
	logic [7:0] edge_blue_q;
	logic       frame_last_q;

	// Line store access.
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	pixel_t        up_rdata;
	pixel_t        mid_rdata;

	// Drain read column.
	logic [XW-1:0] dcol;
	logic          dcol_ok;

	// Emission load.
	logic          emit_ld;
	logic [RW-1:0] ld_row;
	logic [AW-1:0] ld_col;
	logic          ld_drain;
	logic          ld_last;
	logic          mid_emit;
	logic          end_case;
	logic          drain_end;

	// Window after the shift of a new pixel.
	pixel_t win_next [9];

	// Border masks and gradients.
	logic [2:0] row_ok;
	logic [2:0] col_ok;
	logic signed [11:0] gx_c [3];
	logic signed [11:0] gy_c [3];

	logic        out_free;

	assign eff_w = (frame_width_q == '0) ? XW'(1) :
		((XW'(frame_width_q) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(frame_width_q));
	assign eff_h = (frame_height_q == '0) ? XW'(1) :
		((XW'(frame_height_q) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : XW'(frame_height_q));

	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign edge_red   = edge_red_q;
	assign edge_green = edge_green_q;
	assign edge_blue  = edge_blue_q;
	assign frame_last = frame_last_q;

	assign dcol    = XW'(out_col_q) + XW'(di_q) - XW'(1);
	assign dcol_ok = !dcol[XW-1] && (dcol < XW'(MAX_WIDTH));

	assign ram_we   = (state_q == ST_PWB);
	assign ram_addr = (state_q == ST_DCHK || state_q == ST_DRD) ? dcol[AW-1:0] : in_col_q;

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_col_q),
		.wdata (mid_rdata),
		.raddr (ram_addr),
		.rdata (up_rdata)
	);

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (ram_addr),
		.rdata (mid_rdata)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k*3]     = window_q[k*3+1];
			win_next[k*3 + 1] = window_q[k*3+2];
		end
		win_next[2] = up_rdata;
		win_next[5] = mid_rdata;
		win_next[8] = pix_q;
	end

	assign mid_emit  = (in_col_q != '0) && (in_row_q != '0);
	assign end_case  = (in_col_q == '0) && (XW'(in_row_q) >= XW'(2));
	assign drain_end = (XW'(out_col_q) + XW'(1) >= eff_w) && (XW'(out_row_q) + XW'(1) < eff_h);

	always_comb begin
		emit_ld  = 1'b0;
		ld_row   = out_row_q;
		ld_col   = out_col_q;
		ld_drain = 1'b0;
		unique case (state_q)
			ST_PRD: begin
				if (XW'(in_row_q) < eff_h && end_case) begin
					emit_ld = 1'b1;
					ld_row  = in_row_q - RW'(2);
					ld_col  = AW'(eff_w - XW'(1));
				end
			end
			ST_PWB: begin
				if (mid_emit) begin
					emit_ld = 1'b1;
					ld_row  = in_row_q - RW'(1);
					ld_col  = in_col_q - AW'(1);
				end
			end
			ST_DCHK: begin
				if (XW'(in_row_q) >= eff_h && drain_end) begin
					emit_ld  = 1'b1;
					ld_drain = 1'b1;
				end
			end
			ST_DRD: begin
				if (di_q == 2'd3) begin
					emit_ld  = 1'b1;
					ld_drain = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ld_last = (XW'(ld_row) + XW'(1) >= eff_h) && (XW'(ld_col) + XW'(1) >= eff_w);
	end

	always_comb begin
		logic [XW-1:0] er;
		logic [XW-1:0] ec;
		logic [7:0]    v [9];
		er = XW'(eo_row_q);
		ec = XW'(eo_col_q);
		row_ok[0] = (er != '0) && (er < eff_h + XW'(1));
		row_ok[1] = er < eff_h;
		row_ok[2] = er + XW'(1) < eff_h;
		col_ok[0] = (ec != '0) && (ec < eff_w + XW'(1));
		col_ok[1] = ec < eff_w;
		col_ok[2] = ec + XW'(1) < eff_w;
		for (int ch = 0; ch < 3; ch++) begin
			for (int k = 0; k < 9; k++) begin
				v[k] = (row_ok[k/3] && col_ok[k%3]) ? pix_chan(taps_q[k], 2'(ch)) : 8'd0;
			end
			gx_c[ch] = ($signed({4'd0, v[2]}) + $signed({3'd0, v[5], 1'b0})
				+ $signed({4'd0, v[8]})) - ($signed({4'd0, v[0]})
				+ $signed({3'd0, v[3], 1'b0}) + $signed({4'd0, v[6]}));
			gy_c[ch] = ($signed({4'd0, v[6]}) + $signed({3'd0, v[7], 1'b0})
				+ $signed({4'd0, v[8]})) - ($signed({4'd0, v[0]})
				+ $signed({3'd0, v[1], 1'b0}) + $signed({4'd0, v[2]}));
		end
	end

	// Configuration and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			end_pend_q  <= 1'b0;
			di_q        <= '0;
			rd_ok_q     <= 1'b0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				window_q[k] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (emit_ld) begin
				if (ld_drain && ld_last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (XW'(ld_col) + XW'(1) >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= ld_row + RW'(1);
				end else begin
					out_col_q <= ld_col + AW'(1);
					out_row_q <= ld_row;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						di_q    <= '0;
						state_q <= (operation == OP_DRAIN) ? ST_DCHK : ST_PRD;
					end
				end
				ST_PRD: begin
					end_pend_q <= emit_ld;
					state_q    <= (XW'(in_row_q) < eff_h) ? ST_PWB : ST_IDLE;
				end
				ST_PWB: begin
					for (int k = 0; k < 9; k++) begin
						window_q[k] <= win_next[k];
					end
					if (XW'(in_col_q) + XW'(1) >= eff_w) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + RW'(1);
					end else begin
						in_col_q <= in_col_q + AW'(1);
					end
					state_q <= (end_pend_q || mid_emit) ? ST_E1 : ST_IDLE;
				end
				ST_DCHK: begin
					di_q    <= 2'd1;
					rd_ok_q <= dcol_ok;
					if (XW'(in_row_q) < eff_h) begin
						state_q <= ST_IDLE;
					end else if (drain_end) begin
						state_q <= ST_E1;
					end else begin
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					di_q    <= di_q + 2'd1;
					rd_ok_q <= dcol_ok;
					if (di_q == 2'd3) begin
						state_q <= ST_E1;
					end
				end
				ST_E1: begin
					state_q <= ST_E2;
				end
				ST_E2: begin
					bit_q   <= 3'd7;
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pix_q <= {blue, green, red};
		end

		if (emit_ld) begin
			eo_row_q <= ld_row;
			eo_col_q <= ld_col;
			last_q   <= ld_last;
		end

		// Taps of a right-edge result: the last two window columns, nothing beyond.
		if ((state_q == ST_PRD && emit_ld) || (state_q == ST_DCHK && drain_end)) begin
			for (int r = 0; r < 3; r++) begin
				taps_q[r*3]     <= window_q[r*3+1];
				taps_q[r*3 + 1] <= window_q[r*3+2];
				taps_q[r*3 + 2] <= '0;
			end
		end else if (state_q == ST_PWB && mid_emit) begin
			for (int k = 0; k < 9; k++) begin
				taps_q[k] <= win_next[k];
			end
		end else if (state_q == ST_DCHK) begin
			for (int k = 6; k < 9; k++) begin
				taps_q[k] <= '0;
			end
		end else if (state_q == ST_DRD) begin
			// Read data of the column issued in the previous cycle.
			taps_q[4'(di_q) - 4'd1] <= rd_ok_q ? up_rdata : '0;
			taps_q[4'(di_q) + 4'd2] <= rd_ok_q ? mid_rdata : '0;
		end

		if (state_q == ST_E1) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_q[ch] <= gx_c[ch];
				gy_q[ch] <= gy_c[ch];
			end
		end

		if (state_q == ST_E2) begin
			for (int ch = 0; ch < 3; ch++) begin
				m4_q[ch] <= {$unsigned(24'(gx_q[ch] * gx_q[ch]))
					+ $unsigned(24'(gy_q[ch] * gy_q[ch]))} << 2;
				n_q[ch]  <= '0;
			end
		end

		// Binary search for the largest n with (2n-1)^2 <= 4m, one bit per cycle.
		if (state_q == ST_SRCH) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [7:0]  t;
				logic [8:0]  d;
				logic [17:0] dd;
				t  = n_q[ch] | (8'd1 << bit_q);
				d  = {t, 1'b0} - 9'd1;
				dd = d * d;
				if ({6'd0, dd} <= m4_q[ch]) begin
					n_q[ch] <= t;
				end
			end
		end

		if (state_q == ST_OUT && out_free) begin
			edge_red_q   <= n_q[0];
			edge_green_q <= n_q[1];
			edge_blue_q  <= n_q[2];
			frame_last_q <= last_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted item did not start work");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_PWB) && $past(state_q == ST_PRD))
		else $error("line store written without a preceding read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> out_valid_q)
		else $error("finished result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH && bit_q == 3'd0) |=> (state_q == ST_OUT))
		else $error("magnitude search did not end after eight steps");

endmodule

// ===== bench/tb_sobel_edge_magnitude_rgb.sv =====
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_rgb;
	import sobel_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [7:0] mag_red;
		logic [7:0] mag_green;
		logic [7:0] mag_blue;
		logic       last;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_PIXEL;
	logic [7:0] red = '0, green = '0, blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] edge_red, edge_green, edge_blue;
	logic frame_last;

	sobel_edge_magnitude_rgb dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state.
	logic [FRAME_WIDTH_W-1:0]  model_width;
	logic [FRAME_HEIGHT_W-1:0] model_height;
	pixel_t upper_row [STORE_DEPTH];
	pixel_t middle_row [STORE_DEPTH];
	pixel_t window [9];
	int in_col, in_row, out_col, out_row;

	edge_result_t expected_edges[$];
	int mismatches = 0;
	int items_sent = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	longint cycles = 0;

	function automatic int eff_width();
		int w;
		w = model_width;
		if (w < 1) w = 1;
		if (w > STORE_DEPTH) w = STORE_DEPTH;
		return w;
	endfunction

	function automatic int eff_height();
		int h;
		h = model_height;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
		return h;
	endfunction

	function automatic logic [7:0] rounded_root(input int gx, input int gy);
		longint m4;
		int n;
		m4 = 4 * (longint'(gx) * gx + longint'(gy) * gy);
		n = 0;
		while (n < 255 && longint'(2 * n + 1) * (2 * n + 1) <= m4) n++;
		return n[7:0];
	endfunction

	function automatic void expect_edge(input pixel_t taps [9], input int orow, input int ocol);
		int w, h, gx, gy, rr, cc, v;
		logic [7:0] mag [3];
		edge_result_t res;
		w = eff_width();
		h = eff_height();
		for (int ch = 0; ch < 3; ch++) begin
			gx = 0;
			gy = 0;
			for (int k = 0; k < 9; k++) begin
				rr = orow + k / 3 - 1;
				cc = ocol + k % 3 - 1;
				if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
					v = taps[k][8*ch +: 8];
					// Sobel kernels: Gx weights by column, Gy by row.
					gx += v * ((k % 3) - 1) * ((k / 3 == 1) ? 2 : 1);
					gy += v * ((k / 3) - 1) * ((k % 3 == 1) ? 2 : 1);
				end
			end
			mag[ch] = rounded_root(gx, gy);
		end
		res.mag_red = mag[0];
		res.mag_green = mag[1];
		res.mag_blue = mag[2];
		res.last = (orow + 1 >= h && ocol + 1 >= w);
		expected_edges.push_back(res);
	endfunction

	function automatic void edge_column_taps(output pixel_t taps [9]);
		for (int r = 0; r < 3; r++) begin
			taps[r*3] = window[r*3+1];
			taps[r*3+1] = window[r*3+2];
			taps[r*3+2] = '0;
		end
	endfunction

	function automatic void advance_output(input int orow, input int ocol);
		if (ocol + 1 >= eff_width()) begin
			out_col = 0;
			out_row = orow + 1;
		end else begin
			out_col = ocol + 1;
			out_row = orow;
		end
	endfunction

	function automatic void predict_item(input logic op, input pixel_t pix);
		int w, h, cc;
		pixel_t taps [9];
		w = eff_width();
		h = eff_height();
		if (op == OP_PIXEL) begin
			if (in_row >= h) return;
			if (in_col == 0 && in_row >= 2) begin
				edge_column_taps(taps);
				expect_edge(taps, in_row - 2, w - 1);
				advance_output(in_row - 2, w - 1);
			end
			for (int k = 0; k < 3; k++) begin
				window[k*3] = window[k*3+1];
				window[k*3+1] = window[k*3+2];
			end
			window[2] = upper_row[in_col];
			window[5] = middle_row[in_col];
			window[8] = pix;
			upper_row[in_col] = middle_row[in_col];
			middle_row[in_col] = pix;
			if (in_col >= 1 && in_row >= 1) begin
				expect_edge(window, in_row - 1, in_col - 1);
				advance_output(in_row - 1, in_col - 1);
			end
			if (in_col + 1 >= w) begin
				in_col = 0;
				in_row++;
			end else begin
				in_col++;
			end
		end else begin
			if (in_row < h) return;
			if (out_col + 1 >= w && out_row + 1 < h) begin
				edge_column_taps(taps);
			end else begin
				for (int d = 0; d < 3; d++) begin
					cc = out_col + d - 1;
					taps[d] = (cc >= 0 && cc < STORE_DEPTH) ? upper_row[cc] : '0;
					taps[3+d] = (cc >= 0 && cc < STORE_DEPTH) ? middle_row[cc] : '0;
					taps[6+d] = '0;
				end
			end
			expect_edge(taps, out_row, out_col);
			if (out_row + 1 >= h && out_col + 1 >= w) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
			end else begin
				advance_output(out_row, out_col);
			end
		end
	endfunction

	// Sends one item; the predictor runs at the edge of the transfer.
	// Valid stays high after the transfer until the next item or an idle wait.
	task automatic send_item(input logic op, input logic [7:0] r, g, b);
		int gap;
		gap = send_burst ? 0 : $urandom_range(15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(op, {b, g, r});
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_FRAME_WIDTH) model_width = value[FRAME_WIDTH_W-1:0];
		else model_height = value[FRAME_HEIGHT_W-1:0];
	endtask

	// Pattern 0 is random, 1 alternates black and white, 2 is all white.
	task automatic run_frame(input int wval, input int hval, input int pattern, input bit noise);
		int total;
		logic [7:0] r, g, b;
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wval));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hval));
		total = eff_width() * eff_height();
		for (int i = 0; i < total; i++) begin
			if (noise && $urandom_range(19) == 0)
				send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
			case (pattern)
				1: begin
					r = (i % 2) ? 8'hFF : 8'h00;
					g = (i % 3) ? 8'hFF : 8'h00;
					b = ((i / eff_width()) % 2) ? 8'hFF : 8'h00;
				end
				2: {r, g, b} = '1;
				default: {r, g, b} = 24'($urandom);
			endcase
			send_item(OP_PIXEL, r, g, b);
		end
		while (in_row >= eff_height()) begin
			if (noise && $urandom_range(9) == 0)
				send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
			send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_strong_edges();
		run_frame(3, 3, 1, 1'b0);
		run_frame(4, 3, 2, 1'b0);
		run_frame(3, 2, 1, 1'b0);
	endtask

	task automatic test_tiny_frames();
		run_frame(0, 0, 0, 1'b0);
		run_frame(1, 3, 1, 1'b0);
		run_frame(5, 1, 0, 1'b0);
		run_frame(2, 2, 0, 1'b0);
	endtask

	task automatic test_ignored_items();
		wait_idle();
		send_item(OP_DRAIN, 8'hFF, 8'h00, 8'hFF);
		run_frame(3, 4, 0, 1'b1);
	endtask

	task automatic test_size_extremes();
		send_burst = 1'b1;
		run_frame(30, 2, 0, 1'b0);
		run_frame(30, 1, 0, 1'b0);
		run_frame(1, 30, 0, 1'b0);
		send_burst = 1'b0;
	endtask

	task automatic test_random_frames();
		int goal;
		goal = items_sent + 600;
		while (items_sent < goal) begin
			send_burst = ($urandom_range(4) == 0);
			recv_burst = ($urandom_range(4) == 0);
			run_frame($urandom_range(12), $urandom_range(8), ($urandom_range(7) == 0),
				($urandom_range(3) == 0));
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;
	endtask

	// Checks every result transfer and draws the receiver's stall per result.
	int stall_left = 0;
	always @(posedge clk) begin
		edge_result_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (out_valid && !out_stall) begin
			got = '{edge_red, edge_green, edge_blue, frame_last};
			if (expected_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_edges.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
			stall_left = recv_burst ? 0 : $urandom_range(15);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	initial begin
		model_width = FRAME_WIDTH_RESET;
		model_height = FRAME_HEIGHT_RESET;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		for (int i = 0; i < 9; i++) window[i] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_strong_edges();
		test_tiny_frames();
		test_ignored_items();
		test_size_extremes();
		test_random_frames();
		wait_idle();
		if (mismatches == 0 && expected_edges.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
